// ===== sv/ntpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants and helpers of the NTP packet classifier with
// statistics counters.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam int unsigned COUNTER_BITS      = 48;
  localparam int unsigned NUM_COUNTERS      = 16;
  localparam int unsigned CNT_IDX_W         = $clog2(NUM_COUNTERS);
  localparam int unsigned ETH_HEADER_BYTES  = 14;
  localparam int unsigned IPV6_HEADER_BYTES = 40;
  localparam int unsigned UDP_HEADER_BYTES  = 8;

  localparam logic [6:0] NTP_START_DEFAULT = 7'(ETH_HEADER_BYTES + UDP_HEADER_BYTES);
  localparam logic [6:0] NTP_START_IPV6    =
      7'(ETH_HEADER_BYTES + UDP_HEADER_BYTES + IPV6_HEADER_BYTES);

  localparam logic [15:0] OFS_TYPE_HI  = 16'd12;
  localparam logic [15:0] OFS_TYPE_LO  = 16'd13;
  localparam logic [15:0] OFS_IP_FIRST = 16'(ETH_HEADER_BYTES);
  localparam logic [15:0] OFS_MAX      = 16'hFFFF;

  localparam logic [15:0] ETH_TYPE_V4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_V6 = 16'h86DD;

  // Item opcodes and result kinds
  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic KIND_CLASS = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // IP classes
  localparam logic [1:0] IP_V4    = 2'd0;
  localparam logic [1:0] IP_V6    = 2'd1;
  localparam logic [1:0] IP_OTHER = 2'd2;

  // NTP classes
  localparam logic [2:0] NTP_NONE      = 3'd0;
  localparam logic [2:0] NTP_V1_NOMODE = 3'd1;
  localparam logic [2:0] NTP_CLIENT    = 3'd2;
  localparam logic [2:0] NTP_SERVER    = 3'd3;
  localparam logic [2:0] NTP_CONTROL   = 3'd4;
  localparam logic [2:0] NTP_PRIVATE   = 3'd5;

  // NTP mode field codes
  localparam logic [2:0] MODE_RESERVED = 3'd0;
  localparam logic [2:0] MODE_CLIENT   = 3'd3;
  localparam logic [2:0] MODE_SERVER   = 3'd4;
  localparam logic [2:0] MODE_CONTROL  = 3'd6;
  localparam logic [2:0] MODE_PRIVATE  = 3'd7;

  localparam logic [5:0] V1_NOMODE_CODE = 6'h08;
  localparam logic [1:0] LI_ALARM       = 2'b11;
  localparam logic [4:0] KOD_ALL_MATCH  = 5'h1F;

  // Counter indexes
  localparam logic [CNT_IDX_W-1:0] CNT_TOTAL_PKTS  = CNT_IDX_W'(0);
  localparam logic [CNT_IDX_W-1:0] CNT_TOTAL_BYTES = CNT_IDX_W'(1);
  localparam logic [CNT_IDX_W-1:0] CNT_V4_PKTS     = CNT_IDX_W'(2);
  localparam logic [CNT_IDX_W-1:0] CNT_V4_BYTES    = CNT_IDX_W'(3);
  localparam logic [CNT_IDX_W-1:0] CNT_V6_PKTS     = CNT_IDX_W'(4);
  localparam logic [CNT_IDX_W-1:0] CNT_V6_BYTES    = CNT_IDX_W'(5);
  localparam logic [CNT_IDX_W-1:0] CNT_V1_NOMODE   = CNT_IDX_W'(6);
  localparam logic [CNT_IDX_W-1:0] CNT_KOD_RATE    = CNT_IDX_W'(11);
  localparam logic [CNT_IDX_W-1:0] CNT_CLIENT      = CNT_IDX_W'(12);
  localparam logic [CNT_IDX_W-1:0] CNT_SERVER      = CNT_IDX_W'(13);
  localparam logic [CNT_IDX_W-1:0] CNT_CONTROL     = CNT_IDX_W'(14);
  localparam logic [CNT_IDX_W-1:0] CNT_PRIVATE     = CNT_IDX_W'(15);

  typedef struct packed {
    logic        opcode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
    logic [3:0]  counter_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  ip_class;
    logic [2:0]  ntp_class;
    logic [2:0]  client_version;
    logic        kod_rate;
    logic [47:0] counter_value;
  } out_item_t;

  // Frame verdict handed from the parser to the counter sequencer and output
  typedef struct packed {
    logic [1:0]              ip_class;
    logic [2:0]              ntp_class;
    logic [2:0]              client_version;
    logic                    kod_rate;
    logic [NUM_COUNTERS-1:0] bump_mask;
  } class_t;

  // Expected bytes 12 to 15 of a RATE kiss-o'-death
  function automatic logic [7:0] rate_byte(logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = 8'h52;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h54;
      default: b = 8'h45;
    endcase
    return b;
  endfunction

  function automatic logic [CNT_IDX_W-1:0] lowest_set(logic [NUM_COUNTERS-1:0] m);
    logic [CNT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_COUNTERS - 1; i >= 0; i--) begin
      if (m[i]) idx = CNT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic is_byte_counter(logic [CNT_IDX_W-1:0] idx);
    return (idx == CNT_TOTAL_BYTES) || (idx == CNT_V4_BYTES) || (idx == CNT_V6_BYTES);
  endfunction

endpackage

// ===== sv/ntpc_ram.sv =====
// ----------------------------------------------------------------------------
// ntpc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ntpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ntpc_parser.sv =====
// ----------------------------------------------------------------------------
// ntpc_parser
// Per-frame byte tracker: captures the ethertype, locates the NTP header,
// records its first byte and the kiss-o'-death pattern, and classifies the
// frame on its last byte.
// ----------------------------------------------------------------------------
module ntpc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_en_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output ntpc_pkg::class_t    class_o
);

  logic [15:0] offset_q, offset_d;
  logic [15:0] ftype_q, ftype_d;
  logic [6:0]  nstart_q, nstart_d;
  logic [7:0]  first_q, first_d;
  logic [4:0]  kod_q, kod_d;
  logic        seen_q, seen_d;

  logic [15:0] start_ext;
  logic [15:0] diff;
  logic        hit_first, hit_stratum, in_rate;

  always_comb begin
    start_ext   = {9'b0, nstart_q};
    diff        = offset_q - start_ext;
    hit_first   = (offset_q == start_ext);
    hit_stratum = (offset_q == start_ext + 16'd1);
    in_rate     = (offset_q >= start_ext) && (diff[15:2] == 14'd3);

    ftype_d = ftype_q;
    if (offset_q == ntpc_pkg::OFS_TYPE_HI) ftype_d = {data_byte_i, ftype_q[7:0]};
    else if (offset_q == ntpc_pkg::OFS_TYPE_LO) ftype_d = {ftype_q[15:8], data_byte_i};

    nstart_d = nstart_q;
    if (offset_q == ntpc_pkg::OFS_IP_FIRST) begin
      if (ftype_q == ntpc_pkg::ETH_TYPE_V4)
        nstart_d = ntpc_pkg::NTP_START_DEFAULT + {1'b0, data_byte_i[3:0], 2'b00};
      else if (ftype_q == ntpc_pkg::ETH_TYPE_V6)
        nstart_d = ntpc_pkg::NTP_START_IPV6;
      else
        nstart_d = ntpc_pkg::NTP_START_DEFAULT;
    end

    first_d = hit_first ? data_byte_i : first_q;
    seen_d  = seen_q | hit_first;

    kod_d = kod_q;
    if (!hit_first) begin
      if (hit_stratum) begin
        if (data_byte_i == 8'd0) kod_d[0] = 1'b1;
      end else if (in_rate) begin
        if (data_byte_i == ntpc_pkg::rate_byte(diff[1:0])) kod_d[{1'b0, diff[1:0]} + 3'd1] = 1'b1;
      end
    end

    offset_d = (offset_q == ntpc_pkg::OFS_MAX) ? offset_q : offset_q + 16'd1;
  end

  // Classification on the updated state, so the last byte itself counts
  always_comb begin
    class_o = '0;
    class_o.bump_mask[ntpc_pkg::CNT_TOTAL_PKTS] = 1'b1;
    if (ftype_d == ntpc_pkg::ETH_TYPE_V4) begin
      class_o.ip_class = ntpc_pkg::IP_V4;
      class_o.bump_mask[ntpc_pkg::CNT_TOTAL_BYTES] = 1'b1;
      class_o.bump_mask[ntpc_pkg::CNT_V4_PKTS]     = 1'b1;
      class_o.bump_mask[ntpc_pkg::CNT_V4_BYTES]    = 1'b1;
    end else if (ftype_d == ntpc_pkg::ETH_TYPE_V6) begin
      class_o.ip_class = ntpc_pkg::IP_V6;
      class_o.bump_mask[ntpc_pkg::CNT_TOTAL_BYTES] = 1'b1;
      class_o.bump_mask[ntpc_pkg::CNT_V6_PKTS]     = 1'b1;
      class_o.bump_mask[ntpc_pkg::CNT_V6_BYTES]    = 1'b1;
    end else begin
      class_o.ip_class = ntpc_pkg::IP_OTHER;
    end

    if (seen_d) begin
      class_o.client_version = first_d[5:3];
      case (first_d[2:0])
        ntpc_pkg::MODE_RESERVED: begin
          if (first_d[5:0] == ntpc_pkg::V1_NOMODE_CODE) begin
            class_o.ntp_class = ntpc_pkg::NTP_V1_NOMODE;
            class_o.bump_mask[ntpc_pkg::CNT_V1_NOMODE] = 1'b1;
          end
        end
        ntpc_pkg::MODE_CLIENT: begin
          class_o.ntp_class = ntpc_pkg::NTP_CLIENT;
          class_o.bump_mask[ntpc_pkg::CNT_CLIENT] = 1'b1;
          // versions one to four have a counter each, after the no-mode one
          if (first_d[5:3] >= 3'd1 && first_d[5:3] <= 3'd4)
            class_o.bump_mask[ntpc_pkg::CNT_V1_NOMODE + {1'b0, first_d[5:3]}] = 1'b1;
        end
        ntpc_pkg::MODE_SERVER: begin
          class_o.ntp_class = ntpc_pkg::NTP_SERVER;
          class_o.bump_mask[ntpc_pkg::CNT_SERVER] = 1'b1;
          if (first_d[7:6] == ntpc_pkg::LI_ALARM && kod_d == ntpc_pkg::KOD_ALL_MATCH) begin
            class_o.kod_rate = 1'b1;
            class_o.bump_mask[ntpc_pkg::CNT_KOD_RATE] = 1'b1;
          end
        end
        ntpc_pkg::MODE_CONTROL: begin
          class_o.ntp_class = ntpc_pkg::NTP_CONTROL;
          class_o.bump_mask[ntpc_pkg::CNT_CONTROL] = 1'b1;
        end
        ntpc_pkg::MODE_PRIVATE: begin
          class_o.ntp_class = ntpc_pkg::NTP_PRIVATE;
          class_o.bump_mask[ntpc_pkg::CNT_PRIVATE] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      ftype_q  <= '0;
      nstart_q <= ntpc_pkg::NTP_START_DEFAULT;
      first_q  <= '0;
      kod_q    <= '0;
      seen_q   <= 1'b0;
    end else if (byte_en_i) begin
      if (last_byte_i) begin
        // frame done: back to the idle frame state
        offset_q <= '0;
        ftype_q  <= '0;
        nstart_q <= ntpc_pkg::NTP_START_DEFAULT;
        first_q  <= '0;
        kod_q    <= '0;
        seen_q   <= 1'b0;
      end else begin
        offset_q <= offset_d;
        ftype_q  <= ftype_d;
        nstart_q <= nstart_d;
        first_q  <= first_d;
        kod_q    <= kod_d;
        seen_q   <= seen_d;
      end
    end
  end

endmodule

// ===== sv/ntpc_counters.sv =====
// ----------------------------------------------------------------------------
// ntpc_counters
// Statistics counter store: a RAM of wrapping counters, a sequencer that
// applies one frame's bumps by read-modify-write, and the counter read port.
// ----------------------------------------------------------------------------
module ntpc_counters (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [ntpc_pkg::NUM_COUNTERS-1:0]      mask_i,
  input  logic [15:0]                            wire_length_i,
  input  logic                                   rd_req_i,
  input  logic [ntpc_pkg::CNT_IDX_W-1:0]         rd_idx_i,
  output logic                                   busy_o,
  output logic [ntpc_pkg::COUNTER_BITS-1:0]      rd_value_o
);

  logic [ntpc_pkg::NUM_COUNTERS-1:0] pend_q, pend_d;
  logic [ntpc_pkg::NUM_COUNTERS-1:0] valid_q, valid_d;
  logic [15:0]                       wlen_q;
  logic                              wr_valid_q;
  logic [ntpc_pkg::CNT_IDX_W-1:0]    wr_addr_q;
  logic                              rd_valid_q;

  logic                              issue;
  logic [ntpc_pkg::CNT_IDX_W-1:0]    seq_addr;
  logic                              ram_re;
  logic [ntpc_pkg::CNT_IDX_W-1:0]    ram_raddr;
  logic [ntpc_pkg::COUNTER_BITS-1:0] ram_rdata;
  logic [ntpc_pkg::COUNTER_BITS-1:0] old_value;
  logic [ntpc_pkg::COUNTER_BITS-1:0] amount;
  logic [ntpc_pkg::COUNTER_BITS-1:0] wdata;

  always_comb begin
    issue     = (pend_q != '0);
    seq_addr  = ntpc_pkg::lowest_set(pend_q);
    ram_re    = issue | rd_req_i;
    ram_raddr = issue ? seq_addr : rd_idx_i;

    // drop the lowest pending bump once its read is issued
    if (start_i)    pend_d = mask_i;
    else if (issue) pend_d = pend_q & (pend_q - {{(ntpc_pkg::NUM_COUNTERS-1){1'b0}}, 1'b1});
    else            pend_d = pend_q;

    // an entry never written reads as zero
    old_value = rd_valid_q ? ram_rdata : '0;
    amount    = ntpc_pkg::is_byte_counter(wr_addr_q) ?
                ntpc_pkg::COUNTER_BITS'(wlen_q) : ntpc_pkg::COUNTER_BITS'(1);
    wdata     = old_value + amount;

    valid_d = valid_q;
    if (wr_valid_q) valid_d[wr_addr_q] = 1'b1;
  end

  ntpc_ram #(
    .Width(ntpc_pkg::COUNTER_BITS),
    .Depth(ntpc_pkg::NUM_COUNTERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_valid_q),
    .waddr_i(wr_addr_q),
    .wdata_i(wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      valid_q    <= '0;
      wr_valid_q <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      valid_q    <= valid_d;
      wr_valid_q <= issue;
      if (ram_re) rd_valid_q <= valid_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) wlen_q <= wire_length_i;
    if (issue)   wr_addr_q <= seq_addr;
  end

  assign busy_o     = issue | wr_valid_q;
  assign rd_value_o = old_value;

endmodule

// ===== sv/ntp_packet_classifier_counters.sv =====
// ----------------------------------------------------------------------------
// ntp_packet_classifier_counters
// NTP traffic classifier for captured Ethernet frames with sixteen
// wrapping statistics counters held in a RAM.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock. A byte that is not the last of its
// frame is always accepted. The last byte of a frame and a counter read each
// need the counter RAM and the holding register: they are held off while
// the holding register cannot move on or the update sequencer is still
// applying the previous frame's bumps (one to six counters, then the final
// write) through the RAM's single read-modify-write path. With frames of a
// few dozen bytes or more the block therefore runs at one byte per clock
// unless the output stalls. A frame's classification and a read's counter
// value pass the holding register and then the output register. Counters
// reset to zero at once through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ntp_packet_classifier_counters (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ntpc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntpc_pkg::out_item_t out_data_o
);

  logic                              is_read, ends_frame, needs_slot;
  logic                              accept, produce;
  logic                              seq_busy;
  logic                              a_valid_q, a_adv, a_free;
  ntpc_pkg::out_item_t               a_item_q, a_item_d;
  logic                              out_valid_q;
  ntpc_pkg::out_item_t               out_q;
  ntpc_pkg::class_t                  verdict;
  logic [ntpc_pkg::COUNTER_BITS-1:0] rd_value;

  always_comb begin
    is_read    = (in_data_i.opcode == ntpc_pkg::OP_READ);
    ends_frame = !is_read && in_data_i.last_byte;
    needs_slot = is_read | ends_frame;
    a_adv      = a_valid_q && (!out_valid_q || out_ready_i);
    a_free     = !a_valid_q || a_adv;
    in_ready_o = !needs_slot || (!seq_busy && a_free);
    accept     = in_valid_i && in_ready_o;
    produce    = accept && needs_slot;

    a_item_d = '0;
    if (is_read) begin
      a_item_d.result_kind = ntpc_pkg::KIND_READ;
    end else begin
      a_item_d.result_kind    = ntpc_pkg::KIND_CLASS;
      a_item_d.ip_class       = verdict.ip_class;
      a_item_d.ntp_class      = verdict.ntp_class;
      a_item_d.client_version = verdict.client_version;
      a_item_d.kod_rate       = verdict.kod_rate;
    end
  end

  ntpc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (accept && !is_read),
    .data_byte_i(in_data_i.data_byte),
    .last_byte_i(in_data_i.last_byte),
    .class_o    (verdict)
  );

  ntpc_counters u_counters (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept && ends_frame),
    .mask_i       (verdict.bump_mask),
    .wire_length_i(in_data_i.wire_length),
    .rd_req_i     (accept && is_read),
    .rd_idx_i     (in_data_i.counter_index),
    .busy_o       (seq_busy),
    .rd_value_o   (rd_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (produce)    a_valid_q <= 1'b1;
      else if (a_adv) a_valid_q <= 1'b0;
      if (a_adv)            out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Read data stays in the RAM output register until the beat moves on
  always_ff @(posedge clk_i) begin
    if (produce) a_item_q <= a_item_d;
    if (a_adv) begin
      out_q <= a_item_q;
      if (a_item_q.result_kind == ntpc_pkg::KIND_READ) out_q.counter_value <= 48'(rd_value);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_slot_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> a_valid_q)
    else $error("result beat did not reach the holding stage");

  seq_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ends_frame) |-> !seq_busy)
    else $error("counter update started while sequencer busy");

  class_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == ntpc_pkg::KIND_CLASS)
      |-> (out_data_o.counter_value == '0))
    else $error("classification beat carries a counter value");

  kod_only_server: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kod_rate) |-> (out_data_o.ntp_class == ntpc_pkg::NTP_SERVER))
    else $error("RATE kiss-o'-death flagged on a non-server packet");

endmodule
